>>> hdl/csi_pkg.sv
`default_nettype none

package csi_pkg;

  // Default coordinate width; the top level hands its parameter down.
  localparam int COORD_WIDTH_DEF = 16;

  // The radius field is fixed at 15 unsigned bits, so its square fits in 30.
  localparam int RADIUS_WIDTH = 15;
  localparam int RSQ_WIDTH    = 2 * RADIUS_WIDTH;

  // Control that travels with an item through the front stages.
  typedef struct packed {
    logic valid;
    logic vert_foot;  // vertical segment and start_y < center_y < end_y
    logic dx_pos;     // end_x > start_x
  } front_ctl_t;

  // Control that travels with an item through the wide product stages.
  typedef struct packed {
    logic valid;
    logic foot;
  } flag_ctl_t;

endpackage

`default_nettype wire

>>> hdl/csi_if.sv
`default_nettype none

interface csi_query_if import csi_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic [RADIUS_WIDTH-1:0]       radius;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;

  modport source (
    output valid, center_x, center_y, radius, start_x, start_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, radius, start_x, start_y, end_x, end_y,
    output ready
  );
endinterface

interface csi_result_if;
  logic valid;
  logic ready;
  logic hit;
  logic near_line;
  logic foot_on_segment;

  modport source (
    output valid, hit, near_line, foot_on_segment,
    input  ready
  );
  modport sink (
    input  valid, hit, near_line, foot_on_segment,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/circle_segment_intersect.sv
`default_nettype none

// Circle against line segment hit test. Each query transaction carries a
// circle (center, 15-bit radius) and a segment (start, end) in signed
// COORD_WIDTH-bit coordinates; each produces exactly one result transaction,
// in order, with near_line (distance from the center to the infinite line is
// strictly below the radius), foot_on_segment (the foot of the perpendicular
// lies strictly between the endpoints, tested on y for a vertical segment and
// on x otherwise, assuming start < end in that axis) and hit, their AND.
// All tests are exact: squared quantities are compared in wide integers, with
// no division, root or rounding. A zero-length segment reports all zeros. The
// block is a six-stage pipeline that takes one transaction every cycle unless
// the output stalls; the edge that accepts a query loads the first stage, and
// its result is presented from the sixth register. The whole pipeline advances
// whenever the output register is empty or its result is being taken, so a
// stalled result holds every stage in place and nothing is dropped.
module circle_segment_intersect import csi_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  csi_query_if.sink   query,
  csi_result_if.source result
);

  localparam int PW  = 2 * COORD_WIDTH + 2;
  localparam int LW  = 2 * COORD_WIDTH + 1;
  localparam int SQW = 2 * LW;
  localparam int RLW = RSQ_WIDTH + LW;

  // Pipeline advance: the output register is free or is being read.
  logic en;
  assign en          = !result.valid || result.ready;
  assign query.ready = en;

  front_ctl_t             front_ctl;
  logic [LW-1:0]          len;
  logic signed [PW-1:0]   crs;
  logic signed [PW-1:0]   dot;
  logic [RSQ_WIDTH-1:0]   rsq;

  flag_ctl_t              wide_ctl;
  logic [SQW-1:0]         nsq;
  logic [RLW-1:0]         rl;

  // Stages one to three: differences, products, and the L, N and D sums.
  csi_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid    (query.valid),
    .center_x (query.center_x),
    .center_y (query.center_y),
    .radius   (query.radius),
    .start_x  (query.start_x),
    .start_y  (query.start_y),
    .end_x    (query.end_x),
    .end_y    (query.end_y),
    .ctl      (front_ctl),
    .len      (len),
    .crs      (crs),
    .dot      (dot),
    .rsq      (rsq)
  );

  // Stages four and five: foot test and the wide squares, split into
  // half-width partial products.
  csi_wide #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_wide (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_ctl (front_ctl),
    .len    (len),
    .crs    (crs),
    .dot    (dot),
    .rsq    (rsq),
    .ctl    (wide_ctl),
    .nsq    (nsq),
    .rl     (rl)
  );

  // Stage six: r*r*L > N*N, then the output register.
  csi_decide #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_decide (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_ctl (wide_ctl),
    .nsq    (nsq),
    .rl     (rl),
    .result (result)
  );

endmodule

`default_nettype wire

>>> hdl/csi_front.sv
`default_nettype none

// Stages one to three: coordinate differences, the seven narrow products,
// and the length, cross and dot sums.
module csi_front import csi_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int DW = COORD_WIDTH + 1,
  localparam int PW = 2 * COORD_WIDTH + 2,
  localparam int LW = 2 * COORD_WIDTH + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          valid,
  input  wire logic signed [COORD_WIDTH-1:0] center_x,
  input  wire logic signed [COORD_WIDTH-1:0] center_y,
  input  wire logic [RADIUS_WIDTH-1:0]       radius,
  input  wire logic signed [COORD_WIDTH-1:0] start_x,
  input  wire logic signed [COORD_WIDTH-1:0] start_y,
  input  wire logic signed [COORD_WIDTH-1:0] end_x,
  input  wire logic signed [COORD_WIDTH-1:0] end_y,
  output front_ctl_t                         ctl,
  output logic [LW-1:0]                      len,
  output logic signed [PW-1:0]               crs,
  output logic signed [PW-1:0]               dot,
  output logic [RSQ_WIDTH-1:0]               rsq
);

  front_ctl_t               s1_ctl;
  logic signed [DW-1:0]     s1_dx, s1_dy, s1_rx, s1_ry;
  logic [RADIUS_WIDTH-1:0]  s1_r;

  front_ctl_t               s2_ctl;
  logic signed [PW-1:0]     s2_dxdx, s2_dydy, s2_dyrx, s2_dxry, s2_dxrx, s2_dyry;
  logic [RSQ_WIDTH-1:0]     s2_rsq;

  logic signed [PW-1:0]     len_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl.valid <= 1'b0;
      s2_ctl.valid <= 1'b0;
      ctl.valid    <= 1'b0;
    end else if (en) begin
      s1_ctl.valid <= valid;
      s2_ctl.valid <= s1_ctl.valid;
      ctl.valid    <= s2_ctl.valid;
    end
    if (en) begin
      // Stage one.
      s1_ctl.vert_foot <= (end_x == start_x) && (start_y < center_y) && (center_y < end_y);
      s1_ctl.dx_pos    <= end_x > start_x;
      s1_dx <= DW'(end_x) - DW'(start_x);
      s1_dy <= DW'(end_y) - DW'(start_y);
      s1_rx <= DW'(center_x) - DW'(start_x);
      s1_ry <= DW'(center_y) - DW'(start_y);
      s1_r  <= radius;
      // Stage two.
      s2_ctl.vert_foot <= s1_ctl.vert_foot;
      s2_ctl.dx_pos    <= s1_ctl.dx_pos;
      s2_dxdx <= PW'(s1_dx) * PW'(s1_dx);
      s2_dydy <= PW'(s1_dy) * PW'(s1_dy);
      s2_dyrx <= PW'(s1_dy) * PW'(s1_rx);
      s2_dxry <= PW'(s1_dx) * PW'(s1_ry);
      s2_dxrx <= PW'(s1_dx) * PW'(s1_rx);
      s2_dyry <= PW'(s1_dy) * PW'(s1_ry);
      s2_rsq  <= RSQ_WIDTH'(s1_r) * RSQ_WIDTH'(s1_r);
      // Stage three.
      ctl.vert_foot <= s2_ctl.vert_foot;
      ctl.dx_pos    <= s2_ctl.dx_pos;
      len <= len_sum[LW-1:0];
      crs <= s2_dyrx - s2_dxry;
      dot <= s2_dxrx + s2_dyry;
      rsq <= s2_rsq;
    end
  end

  // Both squares are below 2^(2*COORD_WIDTH), so the sum fits in LW bits.
  assign len_sum = s2_dxdx + s2_dydy;

endmodule

`default_nettype wire

>>> hdl/csi_wide.sv
`default_nettype none

// Stages four and five: the foot test, and the two wide squared quantities
// r*r*L and N*N built from half-width partial products.
module csi_wide import csi_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int PW  = 2 * COORD_WIDTH + 2,
  localparam int LW  = 2 * COORD_WIDTH + 1,
  localparam int MW  = LW,
  localparam int H   = (MW + 1) / 2,
  localparam int HW  = MW - H,
  localparam int SQW = 2 * MW,
  localparam int RLW = RSQ_WIDTH + LW
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire front_ctl_t            in_ctl,
  input  wire logic [LW-1:0]         len,
  input  wire logic signed [PW-1:0]  crs,
  input  wire logic signed [PW-1:0]  dot,
  input  wire logic [RSQ_WIDTH-1:0]  rsq,
  output flag_ctl_t                  ctl,
  output logic [SQW-1:0]             nsq,
  output logic [RLW-1:0]             rl
);

  flag_ctl_t                s4_ctl;
  logic [2*H-1:0]           s4_ll;
  logic [H+HW-1:0]          s4_lh;
  logic [2*HW-1:0]          s4_hh;
  logic [RSQ_WIDTH+H-1:0]   s4_rlo;
  logic [RSQ_WIDTH+HW-1:0]  s4_rhi;

  logic signed [PW-1:0]     crs_abs;
  logic [MW-1:0]            mag;
  logic                     foot;

  // |N| is below 2^(2*COORD_WIDTH+1), so MW bits hold it.
  assign crs_abs = crs[PW-1] ? -crs : crs;
  assign mag     = crs_abs[MW-1:0];

  assign foot = in_ctl.vert_foot ||
                (in_ctl.dx_pos && (dot > 0) && (dot < $signed({1'b0, len})));

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_ctl.valid <= 1'b0;
      ctl.valid    <= 1'b0;
    end else if (en) begin
      s4_ctl.valid <= in_ctl.valid;
      ctl.valid    <= s4_ctl.valid;
    end
    if (en) begin
      s4_ctl.foot <= foot;
      s4_ll  <= (2*H)'(mag[H-1:0]) * (2*H)'(mag[H-1:0]);
      s4_lh  <= (H+HW)'(mag[H-1:0]) * (H+HW)'(mag[MW-1:H]);
      s4_hh  <= (2*HW)'(mag[MW-1:H]) * (2*HW)'(mag[MW-1:H]);
      s4_rlo <= (RSQ_WIDTH+H)'(rsq) * (RSQ_WIDTH+H)'(len[H-1:0]);
      s4_rhi <= (RSQ_WIDTH+HW)'(rsq) * (RSQ_WIDTH+HW)'(len[LW-1:H]);

      ctl.foot <= s4_ctl.foot;
      nsq <= (SQW'(s4_hh) << (2 * H)) + (SQW'(s4_lh) << (H + 1)) + SQW'(s4_ll);
      rl  <= (RLW'(s4_rhi) << H) + RLW'(s4_rlo);
    end
  end

endmodule

`default_nettype wire

>>> hdl/csi_decide.sv
`default_nettype none

// Stage six: the distance compare, held in the output register.
module csi_decide import csi_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int LW  = 2 * COORD_WIDTH + 1,
  localparam int SQW = 2 * LW,
  localparam int RLW = RSQ_WIDTH + LW,
  localparam int CW  = (SQW > RLW) ? SQW : RLW
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire flag_ctl_t       in_ctl,
  input  wire logic [SQW-1:0]  nsq,
  input  wire logic [RLW-1:0]  rl,
  csi_result_if.source         result
);

  logic near;

  // A zero-length segment gives L = 0 and N = 0, so near stays low.
  assign near = CW'(rl) > CW'(nsq);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.near_line       <= near;
      result.foot_on_segment <= in_ctl.foot;
      result.hit             <= near && in_ctl.foot;
    end
  end

endmodule

`default_nettype wire
